>>> rtl/gld_pkg.sv
// shared types and constants for the gif lzw pixel decoder
`timescale 1ns / 1ps
package gld_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int CODE_W = ADDR_W + 1;

  localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(TABLE_SIZE + 2);
  localparam logic [CODE_W-1:0] TABLE_LIMIT = CODE_W'(TABLE_SIZE);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_PIXEL    = 3'd2;
  localparam logic [2:0] ST_CLEAR    = 3'd3;
  localparam logic [2:0] ST_NEED     = 3'd4;
  localparam logic [2:0] ST_END      = 3'd5;
  localparam logic [2:0] ST_DEFECT   = 3'd6;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_TRACE
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_POP,
    CMD_STEP
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic to_pop;
    logic to_trace;
    logic trace_done;
  } dp_status_t;

endpackage

>>> rtl/gld_ctrl.sv
// controller state machine for the gif lzw pixel decoder
`timescale 1ns / 1ps
module gld_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gld_pkg::dp_status_t sts,
  output gld_pkg::cmd_t      cmd
);

  gld_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gld_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gld_pkg::S_IDLE: begin
        if (in_valid) state_nxt = gld_pkg::S_EXEC;
      end
      gld_pkg::S_EXEC: begin
        if (sts.out_free) begin
          if (sts.to_pop) state_nxt = gld_pkg::S_POP;
          else if (sts.to_trace) state_nxt = gld_pkg::S_TRACE;
          else state_nxt = gld_pkg::S_IDLE;
        end
      end
      gld_pkg::S_POP: state_nxt = gld_pkg::S_IDLE;
      gld_pkg::S_TRACE: begin
        if (sts.trace_done) state_nxt = gld_pkg::S_IDLE;
      end
      default: state_nxt = gld_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = gld_pkg::CMD_NONE;
    unique case (state_r)
      gld_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = gld_pkg::CMD_LATCH;
      end
      gld_pkg::S_EXEC: begin
        if (sts.out_free) cmd = gld_pkg::CMD_EXEC;
      end
      gld_pkg::S_POP: cmd = gld_pkg::CMD_POP;
      gld_pkg::S_TRACE: cmd = gld_pkg::CMD_STEP;
      default: cmd = gld_pkg::CMD_NONE;
    endcase
  end

endmodule

>>> rtl/gld_dp.sv
// datapath of the gif lzw pixel decoder: reservoir, dictionary, stack, result register
`timescale 1ns / 1ps
module gld_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gld_pkg::cmd_t       cmd,
  output gld_pkg::dp_status_t sts,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_data_byte,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_min_code_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [7:0]          out_pixel
);

  localparam int AW = gld_pkg::ADDR_W;
  localparam int CW = gld_pkg::CODE_W;

  logic [AW-1:0] prefix_mem [gld_pkg::TABLE_SIZE];
  logic [7:0]    suffix_mem [gld_pkg::TABLE_SIZE];
  logic [7:0]    stack_mem  [gld_pkg::TABLE_SIZE];

  logic [3:0]  mcs_r, act_min_r, act_min_nxt;
  logic [1:0]  op_r;
  logic [7:0]  byte_r;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [31:0] res_r, res_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [CW-1:0] nfc_r, nfc_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [CW-1:0] prev_r, prev_nxt;
  logic [7:0]  prev_first_r, prev_first_nxt;
  logic        ended_r, ended_nxt;
  logic [AW-1:0] code_r, code_nxt;
  logic        kw_r, kw_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  pixel_r, pixel_nxt;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr, tbl_wpre, tbl_raddr, pre_q;
  logic [7:0]    tbl_wsuf, suf_q;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_q;

  logic [3:0]    clamp_min;
  logic [CW-1:0] clear_c, end_c, nfc_inc;
  logic [AW-1:0] code_c;
  logic          add_en;
  logic [7:0]    add_first;
  logic [7:0]    first_c;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_pixel  = pixel_r;

  always_comb begin
    if (mcs_r < 4'd2) clamp_min = 4'd2;
    else if (mcs_r > 4'd8) clamp_min = 4'd8;
    else clamp_min = mcs_r;
  end

  assign clear_c = CW'(1) << act_min_r;
  assign end_c   = clear_c + CW'(1);
  assign code_c  = AW'(res_r & ((32'd1 << cw_r) - 32'd1));
  assign nfc_inc = nfc_r + CW'(1);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      prefix_mem[tbl_waddr] <= tbl_wpre;
      suffix_mem[tbl_waddr] <= tbl_wsuf;
    end
    pre_q <= prefix_mem[tbl_raddr];
    suf_q <= suffix_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    stk_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r        <= gld_pkg::MIN_SIZE_RESET;
      act_min_r    <= gld_pkg::MIN_SIZE_RESET;
      depth_r      <= '0;
      res_r        <= '0;
      cnt_r        <= '0;
      nfc_r        <= (CW'(1) << gld_pkg::MIN_SIZE_RESET) + CW'(2);
      cw_r         <= gld_pkg::MIN_SIZE_RESET + 4'd1;
      prev_r       <= gld_pkg::NONE_CODE;
      ended_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) mcs_r <= cfg_min_code_size;
      act_min_r    <= act_min_nxt;
      depth_r      <= depth_nxt;
      res_r        <= res_nxt;
      cnt_r        <= cnt_nxt;
      nfc_r        <= nfc_nxt;
      cw_r         <= cw_nxt;
      prev_r       <= prev_nxt;
      ended_r      <= ended_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == gld_pkg::CMD_LATCH) begin
      op_r   <= in_op;
      byte_r <= in_data_byte;
    end
    prev_first_r <= prev_first_nxt;
    code_r       <= code_nxt;
    kw_r         <= kw_nxt;
    status_r     <= status_nxt;
    pixel_r      <= pixel_nxt;
  end

  always_comb begin
    act_min_nxt    = act_min_r;
    depth_nxt      = depth_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    nfc_nxt        = nfc_r;
    cw_nxt         = cw_r;
    prev_nxt       = prev_r;
    prev_first_nxt = prev_first_r;
    ended_nxt      = ended_r;
    code_nxt       = code_r;
    kw_nxt         = kw_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    status_nxt     = status_r;
    pixel_nxt      = pixel_r;
    tbl_we         = 1'b0;
    tbl_waddr      = nfc_r[AW-1:0];
    tbl_wpre       = prev_r[AW-1:0];
    tbl_wsuf       = '0;
    tbl_raddr      = code_c;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[AW-1:0];
    stk_wdata      = suf_q;
    stk_raddr      = AW'(depth_r - CW'(1));
    add_en         = 1'b0;
    add_first      = '0;
    first_c        = pre_q[7:0];
    sts.out_free   = !out_valid_r || out_ready;
    sts.to_pop     = 1'b0;
    sts.to_trace   = 1'b0;
    sts.trace_done = 1'b0;

    case (cmd)
      gld_pkg::CMD_EXEC: begin
        out_valid_nxt = 1'b1;
        pixel_nxt = '0;
        case (op_r)
          gld_pkg::OP_START: begin
            act_min_nxt = clamp_min;
            depth_nxt   = '0;
            res_nxt     = '0;
            cnt_nxt     = '0;
            ended_nxt   = 1'b0;
            nfc_nxt     = (CW'(1) << clamp_min) + CW'(2);
            cw_nxt      = clamp_min + 4'd1;
            prev_nxt    = gld_pkg::NONE_CODE;
            status_nxt  = gld_pkg::ST_ACCEPTED;
          end
          gld_pkg::OP_PUSH: begin
            if (cnt_r > 6'd24) begin
              status_nxt = gld_pkg::ST_FULL;
            end else begin
              res_nxt    = res_r | (32'(byte_r) << cnt_r);
              cnt_nxt    = cnt_r + 6'd8;
              status_nxt = gld_pkg::ST_ACCEPTED;
            end
          end
          gld_pkg::OP_PULL: begin
            if (depth_r != '0) begin
              depth_nxt     = depth_r - CW'(1);
              out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
              sts.to_pop    = 1'b1;
            end else if (ended_r) begin
              status_nxt = gld_pkg::ST_END;
            end else if (cnt_r < 6'(cw_r)) begin
              status_nxt = gld_pkg::ST_NEED;
            end else begin
              res_nxt  = res_r >> cw_r;
              cnt_nxt  = cnt_r - 6'(cw_r);
              code_nxt = code_c;
              if (CW'(code_c) == clear_c) begin
                nfc_nxt    = clear_c + CW'(2);
                cw_nxt     = act_min_r + 4'd1;
                prev_nxt   = gld_pkg::NONE_CODE;
                status_nxt = gld_pkg::ST_CLEAR;
              end else if (CW'(code_c) == end_c) begin
                ended_nxt  = 1'b1;
                status_nxt = gld_pkg::ST_END;
              end else if (CW'(code_c) < clear_c) begin
                add_en         = 1'b1;
                add_first      = code_c[7:0];
                prev_nxt       = CW'(code_c);
                prev_first_nxt = code_c[7:0];
                pixel_nxt      = code_c[7:0];
                status_nxt     = gld_pkg::ST_PIXEL;
              end else if (CW'(code_c) < nfc_r) begin
                kw_nxt        = 1'b0;
                out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
                sts.to_trace  = 1'b1;
              end else if (CW'(code_c) == nfc_r && prev_r != gld_pkg::NONE_CODE &&
                           nfc_r < gld_pkg::TABLE_LIMIT) begin
                // known-string-repeat case: entry is previous code plus its first pixel
                add_en    = 1'b1;
                add_first = prev_first_r;
                kw_nxt    = 1'b1;
                stk_we    = 1'b1;
                stk_wdata = prev_first_r;
                depth_nxt = depth_r + CW'(1);
                if (prev_r > end_c) begin
                  tbl_raddr     = prev_r[AW-1:0];
                  out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
                  sts.to_trace  = 1'b1;
                end else begin
                  prev_nxt   = CW'(code_c);
                  pixel_nxt  = prev_first_r;
                  status_nxt = gld_pkg::ST_PIXEL;
                end
              end else begin
                status_nxt = gld_pkg::ST_DEFECT;
              end
            end
          end
          default: status_nxt = gld_pkg::ST_DEFECT;
        endcase
      end
      gld_pkg::CMD_POP: begin
        out_valid_nxt = 1'b1;
        status_nxt    = gld_pkg::ST_PIXEL;
        pixel_nxt     = stk_q;
      end
      gld_pkg::CMD_STEP: begin
        if (depth_r < gld_pkg::TABLE_LIMIT) begin
          stk_we    = 1'b1;
          stk_wdata = suf_q;
          depth_nxt = depth_r + CW'(1);
        end
        tbl_raddr = pre_q;
        if (CW'(pre_q) <= end_c) begin
          sts.trace_done = 1'b1;
          if (!kw_r) begin
            add_en    = 1'b1;
            add_first = first_c;
          end
          prev_nxt       = CW'(code_r);
          prev_first_nxt = first_c;
          out_valid_nxt  = 1'b1;
          status_nxt     = gld_pkg::ST_PIXEL;
          pixel_nxt      = first_c;
        end
      end
      default: ;
    endcase

    if (add_en && prev_r != gld_pkg::NONE_CODE && nfc_r < gld_pkg::TABLE_LIMIT) begin
      tbl_we   = 1'b1;
      tbl_wsuf = add_first;
      nfc_nxt  = nfc_inc;
      if (cw_r < 4'(gld_pkg::MAX_CODE_BITS) && nfc_inc == (CW'(1) << cw_r)) begin
        cw_nxt = cw_r + 4'd1;
      end
    end
  end

endmodule

>>> rtl/gif_lzw_pixel_decoder.sv
// top level of the gif lzw pixel decoder
`timescale 1ns / 1ps
// Decodes a GIF LZW stream (LSB-first, 3 to 12 bit codes) one transaction at a
// time: op 0 starts an image, op 1 pushes a byte into the 32-bit bit reservoir,
// op 2 pulls one pixel, answering with one status/pixel result each. Start,
// push and literal or control codes are latched in idle and executed in exec,
// a pop from the string stack passes idle, exec and pop, and a table code
// passes idle and exec and then walks its prefix links in trace; a code equal
// to the next free code has its last pixel stacked at once. The prefix chain
// is walked one entry per cycle through the synchronous dictionary memory
// while the tail is written to the stack. A result still held on the output
// stalls the next one until out_ready is high. The minimum code size written
// on the cfg port takes effect at the next start; the block accepts a new
// transaction while the previous result waits on the output.
module gif_lzw_pixel_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_min_code_size,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_pixel
);

  gld_pkg::cmd_t       cmd;
  gld_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  gld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gld_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_min_code_size (cfg_min_code_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_pixel         (out_pixel)
  );

endmodule
